// File: hdl/ntbl_pkg.sv
// Shared types and codes for the neighbor table with aging.
// Used by the controller, the datapath and the top level.
package ntbl_pkg;

   localparam int unsigned NumEntries = 16;
   localparam int unsigned SlotW      = 4;

   // Input item actions
   localparam logic [2:0] ACT_HELLO  = 3'd0;
   localparam logic [2:0] ACT_UPDATE = 3'd1;
   localparam logic [2:0] ACT_SWEEP  = 3'd2;
   localparam logic [2:0] ACT_LOOKUP = 3'd3;
   localparam logic [2:0] ACT_COUNT  = 3'd4;

   // Result status codes
   localparam logic [3:0] ST_UPDATED = 4'd0;
   localparam logic [3:0] ST_ADDED   = 4'd1;
   localparam logic [3:0] ST_FULL    = 4'd2;
   localparam logic [3:0] ST_OWN     = 4'd3;
   localparam logic [3:0] ST_LOST    = 4'd4;
   localparam logic [3:0] ST_NONE    = 4'd5;
   localparam logic [3:0] ST_FOUND   = 4'd6;
   localparam logic [3:0] ST_ABSENT  = 4'd7;
   localparam logic [3:0] ST_COUNT   = 4'd8;

   // Register indexes
   localparam logic [1:0] REG_OWN_ID  = 2'd0;
   localparam logic [1:0] REG_TIMEOUT = 2'd1;
   localparam logic [1:0] REG_SWEEP   = 2'd2;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] node_id;
      logic [47:0] mac_address;
      logic        by_mac;
      logic signed [7:0] signal_strength;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [3:0]  slot;
      logic [15:0] entry_node_id;
      logic [47:0] entry_mac;
      logic signed [7:0] entry_rssi;
      logic [31:0] entry_last_seen;
      logic [4:0]  valid_count;
      logic        last;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic             load;     // capture the input item
      logic             scan;     // examine the entry at idx
      logic [SlotW-1:0] idx;
      logic             write_hit;  // refresh matched entry
      logic             write_new;  // fill free entry
      logic             emit;       // register a result for rsp_strobe
      logic [3:0]       status;
      logic             use_entry;  // result shows the entry at slot
      logic             echo_in;    // result echoes the input
      logic             drop;       // invalidate entry idx (sweep)
      logic             last;
   } ctl_type;

   // Datapath to controller status
   typedef struct packed {
      logic [2:0]       action;
      logic             own;       // hello carries own id
      logic             match;     // entry at idx matches key
      logic             free;      // entry at idx is empty
      logic             expired;   // entry at idx timed out
      logic             later;     // some slot above idx timed out
      logic             sweep_on;
   } sts_type;

endpackage

// File: hdl/ntbl_ctrl.sv
// Controller state machine: walks the table one slot a cycle.
// Depends on ntbl_pkg.
module ntbl_ctrl import ntbl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output ctl_type ctl
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CHECK = 5'b00010,
      S_FIND  = 5'b00100,
      S_FREE  = 5'b01000,
      S_SWEEP = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [SlotW-1:0] idx_ff, idx_in;
   logic             lost_ff, lost_in;
   logic [SlotW-1:0] free_ff, free_in;
   logic             has_free_ff, has_free_in;

   logic at_end;
   assign at_end = (idx_ff == SlotW'(NumEntries - 1));
   assign busy   = (state_ff != S_IDLE);

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      lost_in     = lost_ff;
      free_in     = free_ff;
      has_free_in = has_free_ff;
      ctl         = '0;
      ctl.idx     = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            idx_in      = '0;
            lost_in     = 1'b0;
            has_free_in = 1'b0;
            case (sts.action)
               ACT_HELLO, ACT_UPDATE: begin
                  if (sts.own) begin
                     ctl.emit = 1'b1; ctl.status = ST_OWN;
                     ctl.echo_in = 1'b1; ctl.last = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_FIND;
                  end
               end
               ACT_LOOKUP: state_in = S_FIND;
               ACT_SWEEP: begin
                  if (sts.sweep_on) state_in = S_SWEEP;
                  else begin
                     ctl.emit = 1'b1; ctl.status = ST_NONE; ctl.last = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               ACT_COUNT: begin
                  ctl.emit = 1'b1; ctl.status = ST_COUNT; ctl.last = 1'b1;
                  state_in = S_IDLE;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_FIND: begin
            ctl.scan = 1'b1;
            if (sts.free && !has_free_ff) begin
               has_free_in = 1'b1;
               free_in     = idx_ff;
            end
            if (sts.match) begin
               ctl.emit = 1'b1; ctl.use_entry = 1'b1; ctl.last = 1'b1;
               if (sts.action == ACT_LOOKUP) ctl.status = ST_FOUND;
               else begin
                  ctl.status = ST_UPDATED; ctl.write_hit = 1'b1;
               end
               state_in = S_IDLE;
            end else if (at_end) begin
               if (sts.action == ACT_LOOKUP) begin
                  ctl.emit = 1'b1; ctl.status = ST_ABSENT; ctl.last = 1'b1;
                  state_in = S_IDLE;
               end else if (has_free_in) begin
                  idx_in   = free_in;
                  state_in = S_FREE;
               end else begin
                  ctl.emit = 1'b1; ctl.status = ST_FULL;
                  ctl.echo_in = 1'b1; ctl.last = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_FREE: begin
            ctl.write_new = 1'b1;
            ctl.emit = 1'b1; ctl.status = ST_ADDED;
            ctl.use_entry = 1'b1; ctl.last = 1'b1;
            state_in = S_IDLE;
         end
         S_SWEEP: begin
            ctl.scan = 1'b1;
            if (sts.expired) begin
               // removed entry is final when no higher slot timed out
               ctl.emit = 1'b1; ctl.status = ST_LOST;
               ctl.use_entry = 1'b1; ctl.drop = 1'b1;
               ctl.last = !sts.later;
               lost_in = 1'b1;
            end else if (at_end && !lost_ff) begin
               // nothing timed out in the whole walk
               ctl.emit = 1'b1; ctl.status = ST_NONE; ctl.last = 1'b1;
            end
            if (at_end) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         idx_ff      <= '0;
         lost_ff     <= 1'b0;
         free_ff     <= '0;
         has_free_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         lost_ff     <= lost_in;
         free_ff     <= free_in;
         has_free_ff <= has_free_in;
      end
   end

endmodule

// File: hdl/ntbl_dp.sv
// Datapath: entry table, input capture, compare and result register.
// Depends on ntbl_pkg.
module ntbl_dp import ntbl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  ctl_type     ctl,
   input  logic [15:0] own_id,
   input  logic [31:0] timeout,
   input  logic        sweep_en,
   output sts_type     sts,
   output logic        rsp_strobe,
   output rsp_type     rsp_data
);

   req_type           cur_ff;
   logic [NumEntries-1:0] valid_ff;
   logic [15:0]       id_ff   [NumEntries];
   logic [47:0]       mac_ff  [NumEntries];
   logic [7:0]        rssi_ff [NumEntries];
   logic [31:0]       time_ff [NumEntries];
   logic              strobe_ff;
   rsp_type           rsp_ff, rsp_in;
   logic [4:0]        count;
   logic [NumEntries-1:0] exp_vec;
   logic              later;
   logic              key_eq;

   // Timed-out flags for every slot, age taken modulo 2^32
   always_comb begin
      for (int i = 0; i < NumEntries; i++)
         exp_vec[i] = valid_ff[i] && ((cur_ff.now_ms - time_ff[i]) > timeout);
   end

   // Any timed-out slot above the scan index
   always_comb begin
      later = 1'b0;
      for (int i = 0; i < NumEntries; i++)
         if (SlotW'(i) > ctl.idx && exp_vec[i]) later = 1'b1;
   end

   // Entry compare at the scan index
   assign key_eq = (cur_ff.action == ACT_LOOKUP && cur_ff.by_mac)
                   ? (mac_ff[ctl.idx] == cur_ff.mac_address)
                   : (id_ff[ctl.idx] == cur_ff.node_id);

   assign sts.action   = cur_ff.action;
   assign sts.own      = (cur_ff.action == ACT_HELLO) && (cur_ff.node_id == own_id);
   assign sts.match    = valid_ff[ctl.idx] && key_eq;
   assign sts.free     = !valid_ff[ctl.idx];
   assign sts.expired  = exp_vec[ctl.idx];
   assign sts.later    = later;
   assign sts.sweep_on = sweep_en;

   // Valid entry count
   always_comb begin
      count = '0;
      for (int i = 0; i < NumEntries; i++) count = count + 5'(valid_ff[i]);
   end

   // Result assembly
   always_comb begin
      rsp_in        = '0;
      rsp_in.status = ctl.status;
      rsp_in.last   = ctl.last;
      if (ctl.use_entry) begin
         rsp_in.slot            = ctl.idx;
         rsp_in.entry_node_id   = ctl.write_new ? cur_ff.node_id : id_ff[ctl.idx];
         rsp_in.entry_mac       = ctl.write_new ? cur_ff.mac_address : mac_ff[ctl.idx];
         rsp_in.entry_rssi      = (ctl.write_hit || ctl.write_new)
                                  ? cur_ff.signal_strength : rssi_ff[ctl.idx];
         rsp_in.entry_last_seen = (ctl.write_hit || ctl.write_new)
                                  ? cur_ff.now_ms : time_ff[ctl.idx];
      end else if (ctl.echo_in) begin
         rsp_in.entry_node_id   = cur_ff.node_id;
         rsp_in.entry_mac       = cur_ff.mac_address;
         rsp_in.entry_rssi      = cur_ff.signal_strength;
         rsp_in.entry_last_seen = cur_ff.now_ms;
      end
      if (ctl.status == ST_COUNT) rsp_in.valid_count = count;
   end

   // Table storage and item capture
   always_ff @(posedge clock) begin
      if (ctl.load) cur_ff <= req_data;
      if (ctl.write_hit || ctl.write_new) begin
         rssi_ff[ctl.idx] <= cur_ff.signal_strength;
         time_ff[ctl.idx] <= cur_ff.now_ms;
      end
      if (ctl.write_new) begin
         id_ff[ctl.idx]  <= cur_ff.node_id;
         mac_ff[ctl.idx] <= cur_ff.mac_address;
      end
      if (ctl.emit) rsp_ff <= rsp_in;
   end

   // Valid bits and strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl.emit;
         if (ctl.write_new) valid_ff[ctl.idx] <= 1'b1;
         if (ctl.drop)      valid_ff[ctl.idx] <= 1'b0;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// File: hdl/neighbor_table_with_aging_top.sv
// Top level of the neighbor table with aging: register port and assembly.
// Depends on ntbl_pkg, ntbl_ctrl and ntbl_dp.
//
// An item is taken when start is high and busy is low. After the taking
// edge busy stays high only through the check state for count, an ignored
// own hello, a disabled sweep or an undefined action; hello, update and
// lookup then walk the 16 slots one per cycle and stop at a hit, and a hello
// or update with no hit then fills the first free slot; an enabled sweep
// always walks all 16 slots. Results come on rsp_strobe, each in the cycle
// after the controller state that makes it; the receiver cannot stall them.
// A sweep reports every removed entry, the highest one marked last, or a
// single "none lost" result when nothing was removed.
module neighbor_table_with_aging_top import ntbl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [15:0] own_ff;
   logic [31:0] tmo_ff;
   logic        swp_ff;
   ctl_type     ctl;
   sts_type     sts;
   logic        wr;
   logic [1:0]  reg_idx;

   assign pready  = 1'b1;
   assign wr      = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff <= 16'hFFFF;
         tmo_ff <= 32'd15000;
         swp_ff <= 1'b0;
      end else if (wr && paddr[1:0] == 2'b00) begin
         unique case (reg_idx)
            REG_OWN_ID:  own_ff <= pwdata[15:0];
            REG_TIMEOUT: tmo_ff <= pwdata;
            REG_SWEEP:   swp_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_OWN_ID:  prdata = {16'd0, own_ff};
         REG_TIMEOUT: prdata = tmo_ff;
         REG_SWEEP:   prdata = {31'd0, swp_ff};
         default:     prdata = '0;
      endcase
   end

   ntbl_ctrl u_ctrl (
      .clock (clock), .reset (reset), .start (start), .busy (busy),
      .sts (sts), .ctl (ctl)
   );

   ntbl_dp u_dp (
      .clock (clock), .reset (reset), .req_data (req_data), .ctl (ctl),
      .own_id (own_ff), .timeout (tmo_ff), .sweep_en (swp_ff), .sts (sts),
      .rsp_strobe (rsp_strobe), .rsp_data (rsp_data)
   );

   // No item is taken while a scan runs
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !ctl.load) else $error("load while busy");
   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |=> rsp_strobe) else $error("result lost");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(ctl.write_hit && ctl.write_new)) else $error("double write");

endmodule
